### src/sip_pkg.sv
package sip_pkg;

    // Width of the fixed-point result coordinates.
    localparam int OUT_BITS = 24;

    // Control flags that ride along with each pair through the pipeline.
    typedef struct packed {
        logic valid;
        logic touch;
        logic coll;
        logic neg_x;
        logic neg_y;
    } flag_t;

    // Applies the sign to a quotient magnitude and saturates it to the output range.
    function automatic logic [OUT_BITS-1:0] sat_signed(
        input logic [OUT_BITS-1:0] q,
        input logic                big,
        input logic                neg
    );
        logic [OUT_BITS-1:0] lim_neg;
        logic [OUT_BITS-1:0] lim_pos;
        logic [OUT_BITS-1:0] res;
        lim_neg = {1'b1, {(OUT_BITS-1){1'b0}}};
        lim_pos = {1'b0, {(OUT_BITS-1){1'b1}}};
        if (neg)
        begin
            if (big || (q > lim_neg))
                res = lim_neg;
            else
                res = (~q) + 1'b1;
        end
        else
        begin
            if (big || q[OUT_BITS-1])
                res = lim_pos;
            else
                res = q;
        end
        return res;
    endfunction

endpackage

### src/segment_intersection_point_unit.sv
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_stall  | a_start_x .. b_end_y, 16 bits signed each
// output  | out       | out_valid / out_stall| touches, collinear, meet_x, meet_y
//
// One segment pair is taken every cycle while no finished result is held by out_stall;
// the divider resolves one quotient bit per stage over the shifted numerator.
// Reset clears the valid bits and the flag words that travel with them from stage 8
// on; the other flags and the data registers are left as they are.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated;
// while the output waits no stage moves and the input is stalled as well.
module segment_intersection_point_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] a_start_x,
    input  logic signed [15:0] a_start_y,
    input  logic signed [15:0] a_end_x,
    input  logic signed [15:0] a_end_y,
    input  logic signed [15:0] b_start_x,
    input  logic signed [15:0] b_start_y,
    input  logic signed [15:0] b_end_x,
    input  logic signed [15:0] b_end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               touches,
    output logic               collinear,
    output logic signed [23:0] meet_x,
    output logic signed [23:0] meet_y
);

    localparam int C   = COORD_BITS;
    localparam int DFW = C + 1;          // coordinate differences
    localparam int PW  = 2 * DFW;        // single cross-product terms
    localparam int XW  = PW + 1;         // cross products, det and tn
    localparam int L   = C + 2;          // low split of det / tn for the multipliers
    localparam int HW  = XW - L;         // high split
    localparam int NW  = 3 * C + 5;      // signed numerator
    localparam int DN  = NW + FRAC_BITS; // numerator after the fraction shift
    localparam int OB  = sip_pkg::OUT_BITS;

    // The whole pipeline moves together unless a finished result is held.
    logic en;
    assign en       = ~out_valid | ~out_stall;
    assign in_stall = ~en;

    // Stage 1: take the coordinates, keeping the low COORD_BITS bits of each field (zero-extended above 16).
    logic [15:0] raw [8];
    assign raw[0] = a_start_x;
    assign raw[1] = a_start_y;
    assign raw[2] = a_end_x;
    assign raw[3] = a_end_y;
    assign raw[4] = b_start_x;
    assign raw[5] = b_start_y;
    assign raw[6] = b_end_x;
    assign raw[7] = b_end_y;

    logic signed [C-1:0] crd_next [8];
    logic signed [C-1:0] crd_reg  [8];
    logic                v1_reg;

    for (genvar i = 0; i < 8; i++)
    begin : g_crd
        if (C <= 16)
        begin : g_narrow
            assign crd_next[i] = signed'(raw[i][C-1:0]);
        end
        else
        begin : g_wide
            assign crd_next[i] = signed'({{(C-16){1'b0}}, raw[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            crd_reg <= crd_next;
    end

    // Stage 2: differences and the bounding-box test.
    logic signed [C-1:0]   ax, ay, ex, ey, bx, by, fx, fy;
    assign ax = crd_reg[0];
    assign ay = crd_reg[1];
    assign ex = crd_reg[2];
    assign ey = crd_reg[3];
    assign bx = crd_reg[4];
    assign by = crd_reg[5];
    assign fx = crd_reg[6];
    assign fy = crd_reg[7];

    logic signed [DFW-1:0] d_reg [12];
    logic signed [C-1:0]   ax2_reg, ay2_reg;
    logic                  hit2_reg;
    logic                  v2_reg;
    logic                  hit_next;

    always_comb
    begin
        hit_next = ((ax < ex ? ax : ex) <= (bx > fx ? bx : fx))
                && ((by < fy ? by : fy) <= (ay > ey ? ay : ey))
                && ((bx < fx ? bx : fx) <= (ax > ex ? ax : ex))
                && ((ay < ey ? ay : ey) <= (by > fy ? by : fy));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]  <= DFW'(ex) - DFW'(ax);   // dax
            d_reg[1]  <= DFW'(ey) - DFW'(ay);   // day
            d_reg[2]  <= DFW'(fx) - DFW'(bx);   // dbx
            d_reg[3]  <= DFW'(fy) - DFW'(by);   // dby
            d_reg[4]  <= DFW'(bx) - DFW'(ax);
            d_reg[5]  <= DFW'(by) - DFW'(ay);
            d_reg[6]  <= DFW'(fx) - DFW'(ax);
            d_reg[7]  <= DFW'(fy) - DFW'(ay);
            d_reg[8]  <= DFW'(ax) - DFW'(bx);
            d_reg[9]  <= DFW'(ay) - DFW'(by);
            d_reg[10] <= DFW'(ex) - DFW'(bx);
            d_reg[11] <= DFW'(ey) - DFW'(by);
            ax2_reg   <= ax;
            ay2_reg   <= ay;
            hit2_reg  <= hit_next;
        end
    end

    // Stage 3: the twelve cross-product terms.
    logic signed [PW-1:0]  p_reg [12];
    logic signed [C-1:0]   ax3_reg, ay3_reg;
    logic signed [DFW-1:0] dax3_reg, day3_reg;
    logic                  hit3_reg;
    logic                  v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= PW'(d_reg[4])  * PW'(d_reg[1]);
            p_reg[1]  <= PW'(d_reg[0])  * PW'(d_reg[5]);
            p_reg[2]  <= PW'(d_reg[6])  * PW'(d_reg[1]);
            p_reg[3]  <= PW'(d_reg[0])  * PW'(d_reg[7]);
            p_reg[4]  <= PW'(d_reg[8])  * PW'(d_reg[3]);
            p_reg[5]  <= PW'(d_reg[2])  * PW'(d_reg[9]);
            p_reg[6]  <= PW'(d_reg[10]) * PW'(d_reg[3]);
            p_reg[7]  <= PW'(d_reg[2])  * PW'(d_reg[11]);
            p_reg[8]  <= PW'(d_reg[0])  * PW'(d_reg[3]);
            p_reg[9]  <= PW'(d_reg[1])  * PW'(d_reg[2]);
            p_reg[10] <= PW'(d_reg[4])  * PW'(d_reg[3]);
            p_reg[11] <= PW'(d_reg[5])  * PW'(d_reg[2]);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            dax3_reg  <= d_reg[0];
            day3_reg  <= d_reg[1];
            hit3_reg  <= hit2_reg;
        end
    end

    // Stage 4: u, v, w, z, det and tn.
    logic signed [XW-1:0]  x_reg [6];
    logic signed [C-1:0]   ax4_reg, ay4_reg;
    logic signed [DFW-1:0] dax4_reg, day4_reg;
    logic                  hit4_reg;
    logic                  v4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                x_reg[i] <= XW'(p_reg[2*i]) - XW'(p_reg[2*i+1]);
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            dax4_reg <= dax3_reg;
            day4_reg <= day3_reg;
            hit4_reg <= hit3_reg;
        end
    end

    // Stage 5: contact decision and split partial products of the numerators.
    logic signed [XW-1:0] det, tn;
    logic                 bad_uv, bad_wz, touch_next;
    logic signed [L:0]    det_lo, tn_lo;
    logic signed [HW-1:0] det_hi, tn_hi;

    assign det    = x_reg[4];
    assign tn     = x_reg[5];
    assign det_lo = signed'({1'b0, det[L-1:0]});
    assign det_hi = det[XW-1:L];
    assign tn_lo  = signed'({1'b0, tn[L-1:0]});
    assign tn_hi  = tn[XW-1:L];
    assign bad_uv = (x_reg[0] != '0) && (x_reg[1] != '0)
                 && (x_reg[0][XW-1] == x_reg[1][XW-1]);
    assign bad_wz = (x_reg[2] != '0) && (x_reg[3] != '0)
                 && (x_reg[2][XW-1] == x_reg[3][XW-1]);
    assign touch_next = hit4_reg & ~bad_uv & ~bad_wz;

    logic signed [NW-1:0] pp_reg [8];
    logic signed [XW-1:0] det5_reg;
    logic                 touch5_reg, coll5_reg;
    logic                 v5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0]  <= NW'(ax4_reg)  * NW'(det_lo);
            pp_reg[1]  <= NW'(ax4_reg)  * NW'(det_hi);
            pp_reg[2]  <= NW'(dax4_reg) * NW'(tn_lo);
            pp_reg[3]  <= NW'(dax4_reg) * NW'(tn_hi);
            pp_reg[4]  <= NW'(ay4_reg)  * NW'(det_lo);
            pp_reg[5]  <= NW'(ay4_reg)  * NW'(det_hi);
            pp_reg[6]  <= NW'(day4_reg) * NW'(tn_lo);
            pp_reg[7]  <= NW'(day4_reg) * NW'(tn_hi);
            det5_reg   <= det;
            touch5_reg <= touch_next;
            coll5_reg  <= touch_next && (det == '0);
        end
    end

    // Stage 6: recombine the split products.
    logic signed [NW-1:0] t6_reg [4];
    logic signed [XW-1:0] det6_reg;
    logic                 touch6_reg, coll6_reg;
    logic                 v6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                t6_reg[i] <= (pp_reg[2*i+1] <<< L) + pp_reg[2*i];
            det6_reg   <= det5_reg;
            touch6_reg <= touch5_reg;
            coll6_reg  <= coll5_reg;
        end
    end

    // Stage 7: numerators A0*det + dA*tn.
    logic signed [NW-1:0] numx7_reg, numy7_reg;
    logic signed [XW-1:0] det7_reg;
    logic                 touch7_reg, coll7_reg;
    logic                 v7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx7_reg  <= t6_reg[0] + t6_reg[1];
            numy7_reg  <= t6_reg[2] + t6_reg[3];
            det7_reg   <= det6_reg;
            touch7_reg <= touch6_reg;
            coll7_reg  <= coll6_reg;
        end
    end

    // Stage 8: magnitudes, result signs and the fraction shift.
    logic [DN-1:0]        numx8_reg, numy8_reg;
    logic [XW-1:0]        den8_reg;
    sip_pkg::flag_t       fl8_reg;
    logic [NW-1:0]        magx, magy;

    assign magx = numx7_reg[NW-1] ? NW'(-numx7_reg) : NW'(numx7_reg);
    assign magy = numy7_reg[NW-1] ? NW'(-numy7_reg) : NW'(numy7_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx8_reg     <= DN'(magx) << FRAC_BITS;
            numy8_reg     <= DN'(magy) << FRAC_BITS;
            den8_reg      <= det7_reg[XW-1] ? XW'(-det7_reg) : XW'(det7_reg);
        end
    end

    // Valid bits of the front stages, and the flags that enter the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            fl8_reg       <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            fl8_reg.valid <= v7_reg;
            fl8_reg.touch <= touch7_reg;
            fl8_reg.coll  <= coll7_reg;
            fl8_reg.neg_x <= numx7_reg[NW-1] ^ det7_reg[XW-1];
            fl8_reg.neg_y <= numy7_reg[NW-1] ^ det7_reg[XW-1];
        end
    end

    // Divider stages, one per numerator bit, with the flags delayed alongside.
    logic [OB-1:0] qx, qy;
    logic          bigx, bigy;

    sip_div #(.NUM_BITS(DN), .DEN_BITS(XW)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx8_reg),
        .den (den8_reg),
        .quo (qx),
        .big (bigx)
    );

    sip_div #(.NUM_BITS(DN), .DEN_BITS(XW)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy8_reg),
        .den (den8_reg),
        .quo (qy),
        .big (bigy)
    );

    sip_pkg::flag_t fl_reg [DN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DN; k++)
                fl_reg[k] <= '0;
        end
        else if (en)
        begin
            fl_reg[0] <= fl8_reg;
            for (int k = 1; k < DN; k++)
                fl_reg[k] <= fl_reg[k-1];
        end
    end

    // Output register: sign, saturation, and zero for no contact or collinear overlap.
    sip_pkg::flag_t fl_end;
    logic           point_ok;
    logic [OB-1:0]  mx_next, my_next;

    assign fl_end   = fl_reg[DN-1];
    assign point_ok = fl_end.touch & ~fl_end.coll;
    assign mx_next  = point_ok ? sip_pkg::sat_signed(qx, bigx, fl_end.neg_x) : '0;
    assign my_next  = point_ok ? sip_pkg::sat_signed(qy, bigy, fl_end.neg_y) : '0;

    logic              out_valid_reg;
    logic              touches_reg, collinear_reg;
    logic [OB-1:0]     meet_x_reg, meet_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fl_end.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            touches_reg   <= fl_end.touch;
            collinear_reg <= fl_end.coll;
            meet_x_reg    <= mx_next;
            meet_y_reg    <= my_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign touches   = touches_reg;
    assign collinear = collinear_reg;
    assign meet_x    = signed'(meet_x_reg);
    assign meet_y    = signed'(meet_y_reg);

    // A collinear overlap is always a contact and never carries a point.
    a_coll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collinear |-> touches && meet_x == '0 && meet_y == '0)
        else $error("collinear result without contact or with a point");

    // Pairs that do not meet report the origin.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !touches |-> meet_x == '0 && meet_y == '0 && !collinear)
        else $error("non-touching result carries a point");

    // An accepted transfer occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transfer lost at pipeline entry");

    // A frozen pipeline keeps its entry stage.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> v1_reg == $past(v1_reg))
        else $error("entry stage changed while stalled");

endmodule

### src/sip_div.sv
// Unsigned restoring divider, one quotient bit per register stage.
module sip_div #(
    parameter int NUM_BITS = 61,
    parameter int DEN_BITS = 35
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NUM_BITS-1:0]           num,
    input  logic [DEN_BITS-1:0]           den,
    output logic [sip_pkg::OUT_BITS-1:0]  quo,
    output logic                          big
);

    localparam int QB = sip_pkg::OUT_BITS;

    logic [DEN_BITS-1:0] rem_reg [NUM_BITS];
    logic [NUM_BITS-1:0] num_reg [NUM_BITS];
    logic [DEN_BITS-1:0] den_reg [NUM_BITS];
    logic [QB-1:0]       quo_reg [NUM_BITS];
    logic                big_reg [NUM_BITS];

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_stage
        logic [DEN_BITS-1:0] rem_cur;
        logic [NUM_BITS-1:0] num_cur;
        logic [DEN_BITS-1:0] den_cur;
        logic [QB-1:0]       quo_cur;
        logic                big_cur;
        logic [DEN_BITS:0]   shifted;
        logic [DEN_BITS+1:0] trial;
        logic                ge;

        if (k == 0)
        begin : g_first
            assign rem_cur = '0;
            assign num_cur = num;
            assign den_cur = den;
            assign quo_cur = '0;
            assign big_cur = 1'b0;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[k-1];
            assign num_cur = num_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign quo_cur = quo_reg[k-1];
            assign big_cur = big_reg[k-1];
        end

        assign shifted = {rem_cur, num_cur[NUM_BITS-1]};
        assign trial   = {1'b0, shifted} - {2'b00, den_cur};
        assign ge      = ~trial[DEN_BITS+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
                num_reg[k] <= {num_cur[NUM_BITS-2:0], 1'b0};
                den_reg[k] <= den_cur;
                quo_reg[k] <= {quo_cur[QB-2:0], ge};
                big_reg[k] <= big_cur | quo_cur[QB-1];
            end
        end
    end

    assign quo = quo_reg[NUM_BITS-1];
    assign big = big_reg[NUM_BITS-1];

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the segment intersection point unit.
//
// A short table of hand-picked segment pairs runs first. Rows whose answer is
// plain from the geometry carry their expected result; the rest are left to the
// predictor below. About 1900 random pairs follow. Most of them are built so
// that the segments actually meet: pairs in windows of varying size, pairs that
// share an endpoint, collinear pairs and corner values. The remainder are
// drawn over the full coordinate range and are mostly misses.
module testbench;

    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 8;
    localparam int RAND_ITEMS = 1900;
    // Pipeline depth of the unit under test, plus a margin.
    localparam int DRAIN_CYCLES = 9 + 3 * COORD_W + 5 + FRAC_W + 30;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t ax, ay, ex, ey, bx, by, fx, fy;
    } seg_pair_t;

    typedef struct {
        logic                                hit;
        logic                                coll;
        logic signed [sip_pkg::OUT_BITS-1:0] px;
        logic signed [sip_pkg::OUT_BITS-1:0] py;
    } meeting_t;

    typedef struct {
        seg_pair_t pair;
        logic      known;
        meeting_t  res;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    coord_t a_start_x, a_start_y, a_end_x, a_end_y;
    coord_t b_start_x, b_start_y, b_end_x, b_end_y;
    logic out_valid;
    logic out_stall;
    logic touches;
    logic collinear;
    logic signed [sip_pkg::OUT_BITS-1:0] meet_x;
    logic signed [sip_pkg::OUT_BITS-1:0] meet_y;

    // Expected meeting results, oldest first.
    meeting_t pending_meetings[$];
    int mismatches = 0;
    int pairs_sent = 0;
    int results_seen = 0;
    int touching_seen = 0;
    int collinear_seen = 0;

    segment_intersection_point_unit #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS(FRAC_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .a_start_x(a_start_x),
        .a_start_y(a_start_y),
        .a_end_x(a_end_x),
        .a_end_y(a_end_y),
        .b_start_x(b_start_x),
        .b_start_y(b_start_y),
        .b_end_x(b_end_x),
        .b_end_y(b_end_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .touches(touches),
        .collinear(collinear),
        .meet_x(meet_x),
        .meet_y(meet_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // (num * 2^FRAC_W) / den, truncated toward zero and saturated to the
    // output range.
    function automatic logic signed [sip_pkg::OUT_BITS-1:0] fixed_quotient(
        input logic signed [127:0] num,
        input longint              den
    );
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] q;
        logic         neg;
        neg = num[127] ^ (den < 0);
        n_mag = num[127] ? -num : num;
        n_mag = n_mag << FRAC_W;
        d_mag = (den < 0) ? 128'(-den) : 128'(den);
        q = n_mag / d_mag;
        if (neg)
        begin
            if (q > 128'd8388608)
                return {1'b1, {(sip_pkg::OUT_BITS-1){1'b0}}};
            return -q[sip_pkg::OUT_BITS-1:0];
        end
        if (q > 128'd8388607)
            return {1'b0, {(sip_pkg::OUT_BITS-1){1'b1}}};
        return q[sip_pkg::OUT_BITS-1:0];
    endfunction

    function automatic int sign_of(input longint v);
        return int'(v > 0) - int'(v < 0);
    endfunction

    function automatic meeting_t predict_meeting(input seg_pair_t p);
        longint ax, ay, ex, ey, bx, by, fx, fy;
        longint dax, day, dbx, dby, u, v, w, z, det, tn;
        logic signed [127:0] w_ax, w_ay, w_dax, w_day, w_det, w_tn;
        meeting_t r;
        ax = p.ax; ay = p.ay; ex = p.ex; ey = p.ey;
        bx = p.bx; by = p.by; fx = p.fx; fy = p.fy;
        r = '{1'b0, 1'b0, '0, '0};
        // Bounding boxes must overlap on both axes.
        if ((ax < ex ? ax : ex) > (bx > fx ? bx : fx) ||
            (by < fy ? by : fy) > (ay > ey ? ay : ey) ||
            (bx < fx ? bx : fx) > (ax > ex ? ax : ex) ||
            (ay < ey ? ay : ey) > (by > fy ? by : fy))
            return r;
        dax = ex - ax; day = ey - ay; dbx = fx - bx; dby = fy - by;
        u = (bx - ax) * day - dax * (by - ay);
        v = (fx - ax) * day - dax * (fy - ay);
        w = (ax - bx) * dby - dbx * (ay - by);
        z = (ex - bx) * dby - dbx * (ey - by);
        if (sign_of(u) * sign_of(v) > 0 || sign_of(w) * sign_of(z) > 0)
            return r;
        r.hit = 1'b1;
        det = dax * dby - day * dbx;
        if (det == 0)
        begin
            r.coll = 1'b1;
            return r;
        end
        tn = (bx - ax) * dby - (by - ay) * dbx;
        w_ax = ax; w_ay = ay; w_dax = dax; w_day = day; w_det = det; w_tn = tn;
        r.px = fixed_quotient(w_ax * w_det + w_dax * w_tn, det);
        r.py = fixed_quotient(w_ay * w_det + w_day * w_tn, det);
        return r;
    endfunction

    function automatic coord_t clip(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return coord_t'(v);
    endfunction

    function automatic coord_t corner_value();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Random pair; the mix leans toward pairs that meet.
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int cx, cy, s, dx, dy, k1, k2;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom)};
            end
            2:
            begin
                p = '{corner_value(), corner_value(), corner_value(), corner_value(),
                      corner_value(), corner_value(), corner_value(), corner_value()};
            end
            3:
            begin
                // Collinear pieces along one direction vector.
                cx = $urandom_range(0, 4000) - 2000;
                cy = $urandom_range(0, 4000) - 2000;
                dx = $urandom_range(0, 40) - 20;
                dy = $urandom_range(0, 40) - 20;
                k1 = $urandom_range(0, 7) - 2;
                k2 = $urandom_range(0, 7) - 2;
                p = '{clip(cx), clip(cy), clip(cx + 3 * dx), clip(cy + 3 * dy),
                      clip(cx + k1 * dx), clip(cy + k1 * dy),
                      clip(cx + k2 * dx), clip(cy + k2 * dy)};
            end
            default:
            begin
                // Four points in a window around a random center.
                case ($urandom_range(0, 2))
                    0: s = 8;
                    1: s = 300;
                    default: s = 32767;
                endcase
                cx = int'(coord_t'($urandom));
                cy = int'(coord_t'($urandom));
                p.ax = clip(cx + $urandom_range(0, 2 * s) - s);
                p.ay = clip(cy + $urandom_range(0, 2 * s) - s);
                p.ex = clip(cx + $urandom_range(0, 2 * s) - s);
                p.ey = clip(cy + $urandom_range(0, 2 * s) - s);
                p.bx = clip(cx + $urandom_range(0, 2 * s) - s);
                p.by = clip(cy + $urandom_range(0, 2 * s) - s);
                p.fx = clip(cx + $urandom_range(0, 2 * s) - s);
                p.fy = clip(cy + $urandom_range(0, 2 * s) - s);
                // Sometimes the segments share an endpoint.
                if ($urandom_range(0, 3) == 0)
                begin
                    p.bx = p.ex;
                    p.by = p.ey;
                end
            end
        endcase
        return p;
    endfunction

    // Directed rows. A known result is typed in only where the geometry
    // gives it at once; the other rows go through the predictor.
    table_row_t directed_rows[] = '{
        // Boxes apart: no contact.
        '{'{0, 0, 10, 0, 20, 5, 30, 5}, 1'b1, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        // Simple X crossing at (5,5).
        '{'{0, 0, 10, 10, 0, 10, 10, 0}, 1'b1, '{1'b1, 1'b0, 24'sd1280, 24'sd1280}},
        // Full-range diagonals meeting at (-0.5,-0.5).
        '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 1'b1,
          '{1'b1, 1'b0, -24'sd128, -24'sd128}},
        // Touch at a shared endpoint (4,0).
        '{'{0, 0, 4, 0, 4, 0, 4, 4}, 1'b1, '{1'b1, 1'b0, 24'sd1024, 24'sd0}},
        // T junction: B ends on the middle of A at (2,0).
        '{'{0, 0, 4, 0, 2, 3, 2, 0}, 1'b1, '{1'b1, 1'b0, 24'sd512, 24'sd0}},
        // Collinear overlap: zero determinant, point forced to zero.
        '{'{0, 0, 10, 0, 5, 0, 20, 0}, 1'b1, '{1'b1, 1'b1, 24'sd0, 24'sd0}},
        // All coordinates zero: two identical points.
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, 1'b1, 24'sd0, 24'sd0}},
        // A degenerate point lying on B.
        '{'{2, 0, 2, 0, 0, 0, 4, 0}, 1'b1, '{1'b1, 1'b1, 24'sd0, 24'sd0}},
        // Collinear but apart along the line.
        '{'{0, 0, 1, 1, 5, 5, 9, 9}, 1'b1, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        // Boxes overlap but B passes beside A.
        '{'{0, 0, 10, 10, 6, 0, 10, 3}, 1'b1, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        // Parallel, boxes overlapping, not touching.
        '{'{0, 0, 10, 10, 0, 1, 10, 11}, 1'b1, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        // Extreme corners, all at the same negative point.
        '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1,
          '{1'b1, 1'b1, 24'sd0, 24'sd0}},
        // Crossings with fractional meeting points.
        '{'{0, 0, 3, 1, 1, 1, 2, -1}, 1'b0, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        '{'{-7, 3, 5, -2, -1, -9, 2, 8}, 1'b0, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        '{'{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32767}, 1'b0,
          '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        '{'{-32768, 0, 32767, 1, 0, -32768, 1, 32767}, 1'b0,
          '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        '{'{-1, -1, 1, 2, -1, 2, 2, -1}, 1'b0, '{1'b0, 1'b0, 24'sd0, 24'sd0}},
        '{'{100, -300, -250, 700, -400, 50, 500, 10}, 1'b0,
          '{1'b0, 1'b0, 24'sd0, 24'sd0}}
    };

    task automatic send_pair(input seg_pair_t p, input meeting_t want, input int gap);
        logic taken;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        a_start_x <= p.ax;
        a_start_y <= p.ay;
        a_end_x   <= p.ex;
        a_end_y   <= p.ey;
        b_start_x <= p.bx;
        b_start_y <= p.by;
        b_end_x   <= p.fx;
        b_end_y   <= p.fy;
        // Outputs settle after each rising edge, so the falling edge gives a
        // race-free look at the stall that the next rising edge will see.
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_meetings = {pending_meetings, want};
        pairs_sent++;
    endtask

    // Stretches of the run with no idling on either side.
    function automatic int draw_wait(input int idx);
        if ((idx % 300) < 60)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Stimulus.
    initial
    begin
        seg_pair_t p;
        in_valid  = 1'b0;
        a_start_x = '0;
        a_start_y = '0;
        a_end_x   = '0;
        a_end_y   = '0;
        b_start_x = '0;
        b_start_y = '0;
        b_end_x   = '0;
        b_end_y   = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            p = directed_rows[i].pair;
            send_pair(p, directed_rows[i].known ? directed_rows[i].res : predict_meeting(p),
                      draw_wait(i + 100));
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // Midway, hold off until the pipeline has drained completely.
            if (i == RAND_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                while (pending_meetings.size() != 0)
                    @(posedge clk);
            end
            p = random_pair();
            send_pair(p, predict_meeting(p), draw_wait(i));
        end
        in_valid <= 1'b0;

        while (pending_meetings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d segment pairs; %0d results checked, %0d touching, %0d collinear.",
                 pairs_sent, results_seen, touching_seen, collinear_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stall before each transfer, then check it.
    initial
    begin
        int n;
        logic taken;
        meeting_t want;
        meeting_t got;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = draw_wait(results_seen);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                taken = out_valid && !out_stall;
                got = '{touches, collinear, meet_x, meet_y};
                @(posedge clk);
            end
            while (!taken);
            results_seen++;
            if (pending_meetings.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_meetings.pop_front();
                if (got.hit) touching_seen++;
                if (got.coll) collinear_seen++;
                if (got.hit !== want.hit)
                begin
                    $error("touches: expected %0d, got %0d", want.hit, got.hit);
                    mismatches++;
                end
                if (got.coll !== want.coll)
                begin
                    $error("collinear: expected %0d, got %0d", want.coll, got.coll);
                    mismatches++;
                end
                if (got.px !== want.px)
                begin
                    $error("meet_x: expected %0d, got %0d", want.px, got.px);
                    mismatches++;
                end
                if (got.py !== want.py)
                begin
                    $error("meet_y: expected %0d, got %0d", want.py, got.py);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: the slowest legal run stays well under this.
    initial
    begin
        #5ms;
        $display("Timed out with %0d results still expected.", pending_meetings.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
src/sip_pkg.sv
src/sip_div.sv
src/segment_intersection_point_unit.sv
sim/testbench.sv
